>>> hdl/vsc_pkg.sv
// ----------------------------------------------------------------------------
// Voxel surface classifier package
// Shared types, microcode word layout, step addresses and class codes.
// ----------------------------------------------------------------------------
package vsc_pkg;

    localparam int PC_W     = 5;
    localparam int CRD_W    = 8;
    localparam int NB_N     = 27;
    localparam int NB_READS = 26;
    localparam int NB_CENTRE = 13;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_WAIT     = 5'd0;
    localparam pc_t PC_RANGE    = 5'd1;
    localparam pc_t PC_WRITE    = 5'd2;
    localparam pc_t PC_CENTRE   = 5'd3;
    localparam pc_t PC_NB_FIRST = 5'd4;
    localparam pc_t PC_DRAIN    = 5'd30;
    localparam pc_t PC_RESULT   = 5'd31;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic OCC_SET    = 1'b1;

    localparam logic [2:0] CLASS_EMPTY  = 3'd0;
    localparam logic [2:0] CLASS_CORNER = 3'd1;
    localparam logic [2:0] CLASS_EDGE   = 3'd2;
    localparam logic [2:0] CLASS_FACE   = 3'd3;
    localparam logic [2:0] CLASS_INSIDE = 3'd4;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ACCEPT,
        COND_OOR,
        COND_WRITE,
        COND_EMPTY,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic              take;
        logic              rd;
        logic              wr;
        logic              load_out;
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
        cond_t             cond;
        pc_t               target;
    } uword_t;

    typedef struct packed {
        logic busy;
        logic is_write;
        logic oor;
        logic centre_empty;
        logic out_free;
    } status_t;

endpackage

>>> hdl/vsc_grid_ram.sv
// ----------------------------------------------------------------------------
// Voxel occupancy grid memory
// Single-port bit memory with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module vsc_grid_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic          wdata,
    output logic          rdata
);

    logic grid_mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            grid_mem[addr] <= wdata;
        end
        rdata_reg <= grid_mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/vsc_sequencer.sv
// ----------------------------------------------------------------------------
// Voxel surface classifier sequencer
// Step counter over a microcode table, with conditional jumps on status.
// ----------------------------------------------------------------------------
module vsc_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  vsc_pkg::status_t  status,
    output vsc_pkg::uword_t   ctrl,
    output logic              in_ready,
    output logic              accept
);

    import vsc_pkg::*;

    localparam logic [5:0] NB_OFS [NB_READS] = '{
        6'b111111, 6'b111100, 6'b111101,
        6'b110011, 6'b110000, 6'b110001,
        6'b110111, 6'b110100, 6'b110101,
        6'b001111, 6'b001100, 6'b001101,
        6'b000011,             6'b000001,
        6'b000111, 6'b000100, 6'b000101,
        6'b011111, 6'b011100, 6'b011101,
        6'b010011, 6'b010000, 6'b010001,
        6'b010111, 6'b010100, 6'b010101
    };

    function automatic uword_t mk(input logic take, input logic rd, input logic wr,
                                  input logic load_out, input logic [5:0] ofs,
                                  input cond_t cond, input pc_t target);
        uword_t w;
        w.take     = take;
        w.rd       = rd;
        w.wr       = wr;
        w.load_out = load_out;
        w.dz       = ofs[5:4];
        w.dy       = ofs[3:2];
        w.dx       = ofs[1:0];
        w.cond     = cond;
        w.target   = target;
        return w;
    endfunction

    function automatic uword_t ucode(input pc_t pc);
        pc_t    nb;
        uword_t w;
        nb = pc_t'(pc - PC_NB_FIRST);
        unique case (pc)
            PC_WAIT:   w = mk(1'b1, 1'b0, 1'b0, 1'b0, 6'b0, COND_ACCEPT, PC_RANGE);
            PC_RANGE:  w = mk(1'b0, 1'b0, 1'b0, 1'b0, 6'b0, COND_OOR, PC_RESULT);
            PC_WRITE:  w = mk(1'b0, 1'b0, 1'b1, 1'b0, 6'b0, COND_WRITE, PC_RESULT);
            PC_CENTRE: w = mk(1'b0, 1'b1, 1'b0, 1'b0, 6'b0, COND_NEXT, PC_WAIT);
            PC_NB_FIRST: begin
                w = mk(1'b0, 1'b1, 1'b0, 1'b0, NB_OFS[0], COND_EMPTY, PC_RESULT);
            end
            PC_DRAIN:  w = mk(1'b0, 1'b0, 1'b0, 1'b0, 6'b0, COND_NEXT, PC_WAIT);
            PC_RESULT: w = mk(1'b0, 1'b0, 1'b0, 1'b1, 6'b0, COND_OUT_FREE, PC_WAIT);
            default:   w = mk(1'b0, 1'b1, 1'b0, 1'b0, NB_OFS[nb], COND_NEXT, PC_WAIT);
        endcase
        return w;
    endfunction

    pc_t pc_reg;
    pc_t pc_next;
    pc_t pc_inc;

    assign ctrl     = ucode(pc_reg);
    assign in_ready = ctrl.take && !status.busy;
    assign accept   = in_ready && s_valid;
    assign pc_inc   = pc_t'(pc_reg + 1'b1);

    always_comb begin
        unique case (ctrl.cond)
            COND_NEXT:     pc_next = pc_inc;
            COND_ACCEPT:   pc_next = accept ? pc_inc : pc_reg;
            COND_OOR:      pc_next = status.oor ? ctrl.target : pc_inc;
            COND_WRITE:    pc_next = status.is_write ? ctrl.target : pc_inc;
            COND_EMPTY:    pc_next = status.centre_empty ? ctrl.target : pc_inc;
            COND_OUT_FREE: pc_next = status.out_free ? ctrl.target : pc_reg;
            default:       pc_next = PC_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> hdl/vsc_datapath.sv
// ----------------------------------------------------------------------------
// Voxel surface classifier datapath
// Item latch, neighbour addressing, neighbour gathering, classification,
// grid clearing after reset and the result register.
// ----------------------------------------------------------------------------
module vsc_datapath #(
    parameter int MAX_DIM = 16,
    parameter int DEPTH   = 4096,
    parameter int AW      = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic             s_func,
    input  logic [3:0]       s_pos_x,
    input  logic [3:0]       s_pos_y,
    input  logic [3:0]       s_pos_z,
    input  logic             s_occupied,
    input  vsc_pkg::uword_t  ctrl,
    input  logic [4:0]       size_x,
    input  logic [4:0]       size_y,
    input  logic [4:0]       size_z,
    input  logic             skip_corner_edge,
    output vsc_pkg::status_t status,
    output logic             ram_we,
    output logic [AW-1:0]    ram_addr,
    output logic             ram_wdata,
    input  logic             ram_rdata,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_voxel_class,
    output logic             m_in_corner_list,
    output logic             m_out_of_range
);

    import vsc_pkg::*;

    function automatic logic [4:0] cell_idx(input int dx, input int dy, input int dz);
        return 5'((dz + 1) * 9 + (dy + 1) * 3 + dx + 1);
    endfunction

    logic                    func_reg;
    logic [3:0]              pos_x_reg;
    logic [3:0]              pos_y_reg;
    logic [3:0]              pos_z_reg;
    logic                    occupied_reg;
    logic [NB_N-1:0]         nb_reg;
    logic                    pend_reg;
    logic                    pend_ok_reg;
    logic [4:0]              pend_idx_reg;
    logic                    clr_busy_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic                    m_valid_reg;
    logic [2:0]              m_class_reg;
    logic                    m_list_reg;
    logic                    m_oor_reg;

    logic signed [CRD_W-1:0] eff_x;
    logic signed [CRD_W-1:0] eff_y;
    logic signed [CRD_W-1:0] eff_z;
    logic signed [CRD_W-1:0] nx;
    logic signed [CRD_W-1:0] ny;
    logic signed [CRD_W-1:0] nz;
    logic                    nb_in_rng;
    logic [AW-1:0]           nb_addr;
    logic                    is_write;
    logic                    out_free;
    logic                    corner_hit;
    logic                    edge_hit;
    logic                    face_hit;
    logic [2:0]              cls;
    logic [2:0]              res_class;

    assign eff_x = (size_x > MAX_DIM) ? CRD_W'(MAX_DIM) : $signed(CRD_W'(size_x));
    assign eff_y = (size_y > MAX_DIM) ? CRD_W'(MAX_DIM) : $signed(CRD_W'(size_y));
    assign eff_z = (size_z > MAX_DIM) ? CRD_W'(MAX_DIM) : $signed(CRD_W'(size_z));

    assign nx = $signed(CRD_W'(pos_x_reg)) + CRD_W'(ctrl.dx);
    assign ny = $signed(CRD_W'(pos_y_reg)) + CRD_W'(ctrl.dy);
    assign nz = $signed(CRD_W'(pos_z_reg)) + CRD_W'(ctrl.dz);

    assign nb_in_rng = !nx[CRD_W-1] && !ny[CRD_W-1] && !nz[CRD_W-1] &&
                       (nx < eff_x) && (ny < eff_y) && (nz < eff_z);

    assign nb_addr = (AW'(nz) * AW'(MAX_DIM) + AW'(ny)) * AW'(MAX_DIM) + AW'(nx);

    assign is_write = (func_reg == FUNC_WRITE);
    assign out_free = !m_valid_reg || m_ready;

    assign ram_we    = clr_busy_reg || (ctrl.wr && is_write && nb_in_rng);
    assign ram_addr  = clr_busy_reg ? clr_addr_reg : nb_addr;
    assign ram_wdata = clr_busy_reg ? 1'b0 : (occupied_reg == OCC_SET);

    assign status.busy         = clr_busy_reg;
    assign status.is_write     = is_write;
    assign status.oor          = !nb_in_rng;
    assign status.centre_empty = !(pend_ok_reg && ram_rdata);
    assign status.out_free     = out_free;

    always_comb begin
        int  ox;
        int  oy;
        int  oz;
        int  sa;
        int  sb;
        logic all_empty;
        corner_hit = 1'b0;
        edge_hit   = 1'b0;
        face_hit   = 1'b0;
        for (int o = 0; o < 8; o++) begin
            ox = o[0] ? -1 : 1;
            oy = o[1] ? -1 : 1;
            oz = o[2] ? -1 : 1;
            all_empty = 1'b1;
            for (int a = 0; a < 2; a++) begin
                for (int b = 0; b < 2; b++) begin
                    for (int c = 0; c < 2; c++) begin
                        if (a + b + c != 0) begin
                            all_empty = all_empty && !nb_reg[cell_idx(a * ox, b * oy, c * oz)];
                        end
                    end
                end
            end
            corner_hit = corner_hit || all_empty;
        end
        for (int s = 0; s < 4; s++) begin
            sa = s[0] ? -1 : 1;
            sb = s[1] ? -1 : 1;
            edge_hit = edge_hit ||
                (!nb_reg[cell_idx(sa, 0, 0)] && !nb_reg[cell_idx(0, sb, 0)] &&
                 !nb_reg[cell_idx(sa, sb, 0)]) ||
                (!nb_reg[cell_idx(0, sa, 0)] && !nb_reg[cell_idx(0, 0, sb)] &&
                 !nb_reg[cell_idx(0, sa, sb)]) ||
                (!nb_reg[cell_idx(sa, 0, 0)] && !nb_reg[cell_idx(0, 0, sb)] &&
                 !nb_reg[cell_idx(sa, 0, sb)]);
        end
        for (int f = 0; f < 2; f++) begin
            sa = f[0] ? -1 : 1;
            face_hit = face_hit || !nb_reg[cell_idx(sa, 0, 0)] ||
                       !nb_reg[cell_idx(0, sa, 0)] || !nb_reg[cell_idx(0, 0, sa)];
        end
    end

    always_comb begin
        priority if (!nb_reg[NB_CENTRE]) begin
            cls = CLASS_EMPTY;
        end else if (!skip_corner_edge && corner_hit) begin
            cls = CLASS_CORNER;
        end else if (!skip_corner_edge && edge_hit) begin
            cls = CLASS_EDGE;
        end else if (face_hit) begin
            cls = CLASS_FACE;
        end else begin
            cls = CLASS_INSIDE;
        end
        res_class = (is_write || !nb_in_rng) ? CLASS_EMPTY : cls;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= s_func;
            pos_x_reg    <= s_pos_x;
            pos_y_reg    <= s_pos_y;
            pos_z_reg    <= s_pos_z;
            occupied_reg <= s_occupied;
        end
        if (accept) begin
            nb_reg <= '0;
        end else if (pend_reg) begin
            nb_reg[pend_idx_reg] <= pend_ok_reg && ram_rdata;
        end
        pend_ok_reg  <= nb_in_rng;
        pend_idx_reg <= cell_idx(int'(ctrl.dx), int'(ctrl.dy), int'(ctrl.dz));
        if (ctrl.load_out && out_free) begin
            m_class_reg <= res_class;
            m_list_reg  <= (res_class == CLASS_CORNER) || (res_class == CLASS_EDGE);
            m_oor_reg   <= !nb_in_rng;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            pend_reg <= ctrl.rd && !clr_busy_reg;
            if (clr_busy_reg) begin
                clr_addr_reg <= AW'(clr_addr_reg + 1'b1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (ctrl.load_out && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_voxel_class    = m_class_reg;
    assign m_in_corner_list = m_list_reg;
    assign m_out_of_range   = m_oor_reg;

endmodule

>>> hdl/voxel_surface_classifier.sv
// ----------------------------------------------------------------------------
// Voxel surface classifier
// Occupancy grid with voxel writes and 26-neighbour surface classification.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Content
//  s_        in         s_valid / s_ready      func, position, occupancy bit
//  m_        out        m_valid / m_ready      class, corner list, range flag
//  APB       in/out     psel, penable, pready  sizes and corner/edge skip
//
//  A query item reads the centre and its 26 neighbours, one grid read per
//  cycle, through the single memory port.
//  A write item ends at its write step, an out-of-range item at its range
//  check and a query of an empty voxel at its first neighbour read.
//  After reset the grid is cleared one voxel a cycle, all MAX_DIM**3 voxels
//  (4096 at the default size), before the first item is taken.
//  A result waits in the output register; the sequencer holds at its
//  result step while that register is full and not being read out.
// ----------------------------------------------------------------------------
module voxel_surface_classifier #(
    parameter int MAX_DIM = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [3:0]  s_pos_x,
    input  logic [3:0]  s_pos_y,
    input  logic [3:0]  s_pos_z,
    input  logic        s_occupied,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_voxel_class,
    output logic        m_in_corner_list,
    output logic        m_out_of_range,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import vsc_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam logic [1:0] REG_SKIP   = 2'd3;

    logic [4:0]    size_x_reg;
    logic [4:0]    size_y_reg;
    logic [4:0]    size_z_reg;
    logic          skip_reg;
    logic          cfg_wr;
    uword_t        ctrl;
    status_t       status;
    logic          accept;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic          ram_wdata;
    logic          ram_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= 5'd16;
            size_y_reg <= 5'd16;
            size_z_reg <= 5'd16;
            skip_reg   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SIZE_X: size_x_reg <= pwdata[4:0];
                REG_SIZE_Y: size_y_reg <= pwdata[4:0];
                REG_SIZE_Z: size_z_reg <= pwdata[4:0];
                REG_SKIP:   skip_reg   <= pwdata[0];
                default:    skip_reg   <= skip_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SIZE_X: prdata = {27'd0, size_x_reg};
            REG_SIZE_Y: prdata = {27'd0, size_y_reg};
            REG_SIZE_Z: prdata = {27'd0, size_z_reg};
            REG_SKIP:   prdata = {31'd0, skip_reg};
            default:    prdata = '0;
        endcase
    end

    vsc_grid_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    vsc_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (s_ready),
        .accept   (accept)
    );

    vsc_datapath #(
        .MAX_DIM (MAX_DIM),
        .DEPTH   (DEPTH),
        .AW      (AW)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .s_func           (s_func),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_occupied       (s_occupied),
        .ctrl             (ctrl),
        .size_x           (size_x_reg),
        .size_y           (size_y_reg),
        .size_z           (size_z_reg),
        .skip_corner_edge (skip_reg),
        .status           (status),
        .ram_we           (ram_we),
        .ram_addr         (ram_addr),
        .ram_wdata        (ram_wdata),
        .ram_rdata        (ram_rdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_voxel_class    (m_voxel_class),
        .m_in_corner_list (m_in_corner_list),
        .m_out_of_range   (m_out_of_range)
    );

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("A second item was taken before the first had finished.");

    a_range_gives_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_voxel_class == CLASS_EMPTY)
        else $error("An out-of-range item carries a class other than empty.");

    a_list_matches_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_in_corner_list ==
            (m_voxel_class == CLASS_CORNER || m_voxel_class == CLASS_EDGE))
        else $error("The corner list flag disagrees with the class.");

endmodule

>>> tb/tb_voxel_surface_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voxel surface classifier testbench
// Drives voxel writes and classification queries through the item channel,
// changes the grid sizes and the corner/edge skip over the register port
// between phases, and compares every result item with an in-house occupancy
// grid model. A directed opening covers each class and the range rules.
// Random phases then build dense shapes in small windows, with some noise.
// ----------------------------------------------------------------------------
module tb_voxel_surface_classifier;
    import vsc_pkg::*;

    localparam int   GRID_DIM    = 16;
    localparam int   GRID_CELLS  = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int   REG_SIZE_X  = 0;
    localparam int   REG_SIZE_Y  = 1;
    localparam int   REG_SIZE_Z  = 2;
    localparam int   REG_SKIP    = 3;
    localparam logic FUNC_QUERY  = 1'b1;
    localparam logic OCC_CLEAR   = 1'b0;
    localparam int   PHASES      = 9;
    localparam int   PHASE_ITEMS = 115;
    localparam int   DRAIN_PAUSE = 40;
    localparam int   STALL_LIMIT = 20000;

    typedef struct packed {
        logic [2:0] voxel_class;
        logic       in_corner_list;
        logic       out_of_range;
    } voxel_result_t;

    class voxel_scoreboard;
        bit            grid [GRID_CELLS];
        logic [4:0]    size_reg [3];
        bit            skip_corner_edge;
        voxel_result_t due_results [$];
        int            errors;
        int            class_seen [5];
        int            oor_seen;
        int            writes_seen;

        function new();
            size_reg = '{5'd16, 5'd16, 5'd16};
            skip_corner_edge = 1'b0;
        endfunction

        function void write_register(int idx, logic [4:0] value);
            if (idx == REG_SKIP) begin
                skip_corner_edge = value[0];
            end else begin
                size_reg[idx] = value;
            end
        endfunction

        function int span(int axis);
            return (size_reg[axis] > GRID_DIM) ? GRID_DIM : int'(size_reg[axis]);
        endfunction

        function bit in_grid(int x, int y, int z);
            return x >= 0 && y >= 0 && z >= 0 &&
                   x < span(0) && y < span(1) && z < span(2);
        endfunction

        function bit filled(int x, int y, int z);
            if (!in_grid(x, y, z)) return 1'b0;
            return grid[(z * GRID_DIM + y) * GRID_DIM + x];
        endfunction

        function bit octant_clear(int x, int y, int z, int dx, int dy, int dz);
            for (int m = 1; m < 8; m++) begin
                if (filled(x + (m[0] ? dx : 0), y + (m[1] ? dy : 0), z + (m[2] ? dz : 0)))
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit edge_clear(int x, int y, int z);
            int fa [3];
            int fb [3];
            for (int a = 0; a < 3; a++)
                for (int b = a + 1; b < 3; b++)
                    for (int sign_a = -1; sign_a <= 1; sign_a += 2)
                        for (int sign_b = -1; sign_b <= 1; sign_b += 2) begin
                            fa = '{0, 0, 0};
                            fb = '{0, 0, 0};
                            fa[a] = sign_a;
                            fb[b] = sign_b;
                            if (!filled(x + fa[0], y + fa[1], z + fa[2]) &&
                                !filled(x + fb[0], y + fb[1], z + fb[2]) &&
                                !filled(x + fa[0] + fb[0], y + fa[1] + fb[1],
                                        z + fa[2] + fb[2]))
                                return 1'b1;
                        end
            return 1'b0;
        endfunction

        function logic [2:0] classify_voxel(int x, int y, int z);
            if (!filled(x, y, z)) return CLASS_EMPTY;
            if (!skip_corner_edge) begin
                for (int dz = -1; dz <= 1; dz += 2)
                    for (int dy = -1; dy <= 1; dy += 2)
                        for (int dx = -1; dx <= 1; dx += 2)
                            if (octant_clear(x, y, z, dx, dy, dz)) return CLASS_CORNER;
                if (edge_clear(x, y, z)) return CLASS_EDGE;
            end
            if (!filled(x + 1, y, z) || !filled(x - 1, y, z) ||
                !filled(x, y + 1, z) || !filled(x, y - 1, z) ||
                !filled(x, y, z + 1) || !filled(x, y, z - 1))
                return CLASS_FACE;
            return CLASS_INSIDE;
        endfunction

        function void note_item(logic func, logic [3:0] x, logic [3:0] y,
                                logic [3:0] z, logic occ);
            voxel_result_t r;
            logic [2:0]    cls;
            cls = CLASS_EMPTY;
            r.out_of_range = !in_grid(x, y, z);
            if (func == FUNC_WRITE) begin
                writes_seen++;
                if (!r.out_of_range) grid[(z * GRID_DIM + y) * GRID_DIM + x] = occ;
            end else if (!r.out_of_range) begin
                cls = classify_voxel(x, y, z);
                class_seen[cls]++;
            end
            if (r.out_of_range) oor_seen++;
            r.voxel_class    = cls;
            r.in_corner_list = (cls == CLASS_CORNER || cls == CLASS_EDGE);
            due_results.push_back(r);
        endfunction

        function void check_result(logic [2:0] cls, logic corner_list, logic oor);
            voxel_result_t want;
            if (due_results.size() == 0) begin
                $error("result item with no item outstanding: voxel_class %0d", cls);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (cls !== want.voxel_class) begin
                $error("voxel_class: expected %0d, got %0d", want.voxel_class, cls);
                errors++;
            end
            if (corner_list !== want.in_corner_list) begin
                $error("in_corner_list: expected %0d, got %0d",
                       want.in_corner_list, corner_list);
                errors++;
            end
            if (oor !== want.out_of_range) begin
                $error("out_of_range: expected %0d, got %0d", want.out_of_range, oor);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [3:0]  s_pos_x;
    logic [3:0]  s_pos_y;
    logic [3:0]  s_pos_z;
    logic        s_occupied;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_voxel_class;
    logic        m_in_corner_list;
    logic        m_out_of_range;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    voxel_scoreboard sb;
    int              send_gap_pct = 29;
    int              recv_gap_pct = 86;
    int              stall_cycles = 0;

    voxel_surface_classifier dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_occupied       (s_occupied),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_voxel_class    (m_voxel_class),
        .m_in_corner_list (m_in_corner_list),
        .m_out_of_range   (m_out_of_range),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_voxel_class, m_in_corner_list, m_out_of_range);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles == STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_item(logic func, logic [3:0] x, logic [3:0] y,
                             logic [3:0] z, logic occ);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= func;
        s_pos_x    <= x;
        s_pos_y    <= y;
        s_pos_z    <= z;
        s_occupied <= occ;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(func, x, y, z, occ);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(int idx, logic [4:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 4);
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_register(idx, value);
    endtask

    task automatic set_config(logic [4:0] sx, logic [4:0] sy, logic [4:0] sz, logic skip);
        wait_drained();
        write_register(REG_SIZE_X, sx);
        write_register(REG_SIZE_Y, sy);
        write_register(REG_SIZE_Z, sz);
        write_register(REG_SKIP, {4'd0, skip});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(int items);
        int         base [3];
        int         spread [3];
        int         extent;
        logic       func;
        logic       occ;
        logic [3:0] crd [3];
        for (int a = 0; a < 3; a++) begin
            extent    = sb.span(a);
            spread[a] = (extent >= 4) ? 3 : ((extent > 0) ? extent - 1 : 0);
            base[a]   = $urandom_range(0, (extent > spread[a] + 1) ?
                                          extent - spread[a] - 1 : 0);
        end
        for (int n = 0; n < items; n++) begin
            if (n < items / 3) begin
                func = FUNC_WRITE;
                occ  = ($urandom_range(0, 99) < 80) ? OCC_SET : OCC_CLEAR;
            end else begin
                func = ($urandom_range(0, 99) < 35) ? FUNC_WRITE : FUNC_QUERY;
                occ  = ($urandom_range(0, 99) < 60) ? OCC_SET : OCC_CLEAR;
            end
            for (int a = 0; a < 3; a++)
                crd[a] = ($urandom_range(0, 99) < 88) ?
                         4'(base[a] + $urandom_range(0, spread[a])) :
                         4'($urandom_range(0, 15));
            send_item(func, crd[0], crd[1], crd[2], occ);
        end
    endtask

    initial begin
        sb = new();
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_func     <= FUNC_WRITE;
        s_pos_x    <= 4'd0;
        s_pos_y    <= 4'd0;
        s_pos_z    <= 4'd0;
        s_occupied <= OCC_CLEAR;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= 4'd0;
        pwdata     <= 32'd0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Build up one voxel step by step so that it passes through every class.
        set_config(5'd16, 5'd16, 5'd16, 1'b0);
        send_item(FUNC_QUERY, 4'd5, 4'd5, 4'd5, OCC_CLEAR);
        send_item(FUNC_WRITE, 4'd5, 4'd5, 4'd5, OCC_SET);
        send_item(FUNC_QUERY, 4'd5, 4'd5, 4'd5, OCC_CLEAR);
        send_item(FUNC_WRITE, 4'd5, 4'd5, 4'd6, OCC_SET);
        send_item(FUNC_WRITE, 4'd5, 4'd5, 4'd4, OCC_SET);
        send_item(FUNC_QUERY, 4'd5, 4'd5, 4'd5, OCC_SET);
        send_item(FUNC_WRITE, 4'd6, 4'd5, 4'd5, OCC_SET);
        send_item(FUNC_WRITE, 4'd4, 4'd5, 4'd5, OCC_SET);
        send_item(FUNC_WRITE, 4'd5, 4'd6, 4'd5, OCC_SET);
        send_item(FUNC_WRITE, 4'd5, 4'd4, 4'd5, OCC_SET);
        send_item(FUNC_QUERY, 4'd5, 4'd5, 4'd5, OCC_CLEAR);
        send_item(FUNC_WRITE, 4'd5, 4'd5, 4'd6, OCC_CLEAR);
        send_item(FUNC_QUERY, 4'd5, 4'd5, 4'd5, OCC_CLEAR);
        send_item(FUNC_WRITE, 4'd15, 4'd15, 4'd15, OCC_SET);
        send_item(FUNC_QUERY, 4'd15, 4'd15, 4'd15, OCC_CLEAR);
        send_item(FUNC_WRITE, 4'd0, 4'd0, 4'd0, OCC_SET);
        send_item(FUNC_QUERY, 4'd0, 4'd0, 4'd0, OCC_CLEAR);
        set_config(5'd4, 5'd16, 5'd16, 1'b1);
        send_item(FUNC_WRITE, 4'd4, 4'd0, 4'd0, OCC_SET);
        send_item(FUNC_QUERY, 4'd4, 4'd0, 4'd0, OCC_CLEAR);
        send_item(FUNC_QUERY, 4'd5, 4'd5, 4'd5, OCC_CLEAR);
        send_item(FUNC_QUERY, 4'd0, 4'd0, 4'd0, OCC_CLEAR);
        set_config(5'd0, 5'd16, 5'd16, 1'b0);
        send_item(FUNC_QUERY, 4'd0, 4'd0, 4'd0, OCC_CLEAR);
        set_config(5'd31, 5'd17, 5'd16, 1'b1);
        send_item(FUNC_QUERY, 4'd5, 4'd5, 4'd5, OCC_CLEAR);
        send_item(FUNC_QUERY, 4'd15, 4'd15, 4'd15, OCC_CLEAR);

        for (int p = 0; p < PHASES; p++) begin
            case (p / 3)
                0: begin
                    send_gap_pct = 29;
                    recv_gap_pct = 86;
                end
                1: begin
                    send_gap_pct = 86;
                    recv_gap_pct = 29;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            case (p)
                0: set_config(5'd16, 5'd16, 5'd16, 1'b0);
                1: set_config(5'd4, 5'd3, 5'd5, 1'b1);
                2: set_config(5'd1, 5'd16, 5'd2, 1'b0);
                3: set_config(5'd31, 5'd17, 5'd16, 1'b1);
                4: set_config(5'd0, 5'd4, 5'd4, 1'b0);
                5: set_config(5'($urandom_range(2, 6)), 5'($urandom_range(2, 6)),
                              5'($urandom_range(2, 6)), 1'($urandom_range(0, 1)));
                6: set_config(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                              5'($urandom_range(1, 16)), 1'($urandom_range(0, 1)));
                7: set_config(5'd3, 5'd3, 5'd3, 1'b0);
                default: set_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                    5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            endcase
            run_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (DRAIN_PAUSE) @(posedge aclk);
        $display("Run covered %0d writes and %0d out-of-range items over %0d settings.",
                 sb.writes_seen, sb.oor_seen, PHASES + 4);
        $display("Queries by class: empty %0d, corner %0d, edge %0d, face %0d, inside %0d.",
                 sb.class_seen[CLASS_EMPTY], sb.class_seen[CLASS_CORNER],
                 sb.class_seen[CLASS_EDGE], sb.class_seen[CLASS_FACE],
                 sb.class_seen[CLASS_INSIDE]);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/vsc_pkg.sv
hdl/vsc_grid_ram.sv
hdl/vsc_sequencer.sv
hdl/vsc_datapath.sv
hdl/voxel_surface_classifier.sv
tb/tb_voxel_surface_classifier.sv
